### rtl/cla_pkg.sv
// Package for the command line assembler: constants, command and result
// transaction types, and the back-end state encoding. No dependencies.
package cla_pkg;

  localparam int LineCapacity = 64;
  localparam int QueueDepth   = 4;
  localparam int ResDepth     = 4;

  localparam logic [6:0] LimitMax  = 7'd64;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] PrintLo   = 8'd32;
  localparam logic [7:0] PrintHi   = 8'd126;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_EOL   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] ch;
    logic [6:0] limit;
  } cmd_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic [5:0] char_index;
    logic       char_valid;
    logic [5:0] line_length;
    logic       last;
  } res_t;

endpackage

### rtl/command_line_assembler_unit.sv
// Top level of the command line assembler: front part, back part and the
// result queue. Uses cla_pkg, cla_front, cla_back and cla_fifo.
//
//   Channel   Handshake          Payload
//   input     push / full        command_i, data_byte_i, read_limit_i
//   result    empty / pop        char_out_o, char_index_o, char_valid_o,
//                                line_length_o, last_o
//
// Ignored bytes never leave the front part. A read gives its characters
// one at a time through the single read port of the line RAM, held while
// the result queue has no room, and a single result when empty.
// The command queue takes up to QueueDepth transactions while a read drains.
// Reset clears counts and queues only; the line RAM needs no clearing pass.
// A stalled result queue holds the back part, which then holds the front.
module command_line_assembler_unit #(
  parameter int LineCapacity = cla_pkg::LineCapacity,
  parameter int QueueDepth   = cla_pkg::QueueDepth,
  parameter int ResDepth     = cla_pkg::ResDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  input  logic [6:0] read_limit_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] char_out_o,
  output logic [5:0] char_index_o,
  output logic       char_valid_o,
  output logic [5:0] line_length_o,
  output logic       last_o
);
  import cla_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;
  logic [$clog2(ResDepth+1)-1:0] res_count;

  cla_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .read_limit_i(read_limit_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  cla_back #(
    .LineCapacity(LineCapacity),
    .ResDepth    (ResDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  cla_fifo #(
    .Width($bits(res_t)),
    .Depth(ResDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .pop_i  (pop),
    .rdata_o(res_out),
    .full_o (res_full),
    .empty_o(empty),
    .count_o(res_count)
  );

  assign char_out_o    = res_out.char_out;
  assign char_index_o  = res_out.char_index;
  assign char_valid_o  = res_out.char_valid;
  assign line_length_o = res_out.line_length;
  assign last_o        = res_out.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("Result transaction lost at a full result queue.");

endmodule

### rtl/cla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cla_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cla_fifo.sv
// Small register-based first-in first-out queue used between the front and
// back parts and for the result queue. No dependencies.
module cla_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] data_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = data_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/cla_front.sv
// Front part: accepts input transactions, classifies bytes, drops ignored
// ones and queues commands for the back part. Uses cla_pkg and cla_fifo.
module cla_front #(
  parameter int QueueDepth = cla_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic          command_i,
  input  logic [7:0]    data_byte_i,
  input  logic [6:0]    read_limit_i,
  input  logic          cmd_pop_i,
  output logic          cmd_valid_o,
  output cla_pkg::cmd_t cmd_o
);
  import cla_pkg::*;

  cmd_t cmd;
  logic keep;
  logic cmd_empty;
  logic [$clog2(QueueDepth+1)-1:0] cmd_count;

  always_comb begin
    cmd.ch    = data_byte_i[6:0];
    cmd.limit = (read_limit_i > LimitMax) ? LimitMax : read_limit_i;
    cmd.op    = OP_READ;
    keep      = 1'b1;
    if (!command_i) begin
      if (data_byte_i == CharCr || data_byte_i == CharLf) begin
        cmd.op = OP_EOL;
      end else if (data_byte_i >= PrintLo && data_byte_i <= PrintHi) begin
        cmd.op = OP_PRINT;
      end else begin
        cmd.op = OP_PRINT;
        keep   = 1'b0;
      end
    end
  end

  cla_fifo #(
    .Width($bits(cmd_t)),
    .Depth(QueueDepth)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && keep),
    .wdata_i(cmd),
    .pop_i  (cmd_pop_i),
    .rdata_o(cmd_o),
    .full_o (full),
    .empty_o(cmd_empty),
    .count_o(cmd_count)
  );

  assign cmd_valid_o = !cmd_empty;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_count != '0)
    else $error("Command queue popped while empty.");

endmodule

### rtl/cla_back.sv
// Back part: keeps the build and pending lines in one line RAM (two halves
// swapped on line end) and reads the pending line out. Uses cla_pkg, cla_ram.
module cla_back #(
  parameter int LineCapacity = cla_pkg::LineCapacity,
  parameter int ResDepth     = cla_pkg::ResDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  cla_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  logic [$clog2(ResDepth+1)-1:0] res_count_i,
  output logic                          res_push_o,
  output cla_pkg::res_t                 res_o
);
  import cla_pkg::*;

  localparam int CntW  = $clog2(LineCapacity);
  localparam int AddrW = CntW + 1;
  localparam int Depth = 2 ** AddrW;

  state_e          state_q, state_d;
  logic [CntW-1:0] build_count_q, build_count_d;
  logic [CntW-1:0] ready_count_q, ready_count_d;
  logic            build_sel_q, build_sel_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d, rd_len_q, rd_len_d;
  logic            pv_q, pv_d;
  logic            p_cv_q, p_cv_d, p_last_q, p_last_d;
  logic [CntW-1:0] p_idx_q, p_idx_d, p_len_q, p_len_d;
  logic            room;
  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [6:0]      rdata;
  logic [6:0]      lim, rc7, n7;

  assign room  = (int'(res_count_i) + int'(pv_q)) < ResDepth;
  assign lim   = cmd_i.limit;
  assign rc7   = 7'(ready_count_q);
  assign n7    = (rc7 >= lim) ? lim - 7'd1 : rc7;
  assign waddr = {build_sel_q, build_count_q};
  assign raddr = {~build_sel_q, rd_idx_q};

  always_comb begin
    state_d       = state_q;
    build_count_d = build_count_q;
    ready_count_d = ready_count_q;
    build_sel_d   = build_sel_q;
    rd_idx_d      = rd_idx_q;
    rd_len_d      = rd_len_q;
    pv_d          = 1'b0;
    p_cv_d        = 1'b0;
    p_last_d      = 1'b1;
    p_idx_d       = '0;
    p_len_d       = '0;
    we            = 1'b0;
    cmd_pop_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_PRINT: begin
              cmd_pop_o = 1'b1;
              if (build_count_q < CntW'(LineCapacity - 1)) begin
                we            = 1'b1;
                build_count_d = build_count_q + CntW'(1);
              end
            end
            OP_EOL: begin
              cmd_pop_o = 1'b1;
              if (build_count_q != '0 && ready_count_q == '0) begin
                ready_count_d = build_count_q;
                build_sel_d   = ~build_sel_q;
              end
              build_count_d = '0;
            end
            OP_READ: begin
              if (room) begin
                cmd_pop_o = 1'b1;
                if (lim == '0 || ready_count_q == '0) begin
                  pv_d = 1'b1;
                end else begin
                  ready_count_d = '0;
                  if (n7 == '0) begin
                    pv_d = 1'b1;
                  end else begin
                    state_d  = ST_READ;
                    rd_idx_d = '0;
                    rd_len_d = n7[CntW-1:0];
                  end
                end
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (room) begin
          pv_d     = 1'b1;
          p_cv_d   = 1'b1;
          p_idx_d  = rd_idx_q;
          p_len_d  = rd_len_q;
          p_last_d = (rd_idx_q == rd_len_q - CntW'(1));
          rd_idx_d = rd_idx_q + CntW'(1);
          if (p_last_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      build_count_q <= '0;
      ready_count_q <= '0;
      build_sel_q   <= 1'b0;
      rd_idx_q      <= '0;
      rd_len_q      <= '0;
      pv_q          <= 1'b0;
    end else begin
      state_q       <= state_d;
      build_count_q <= build_count_d;
      ready_count_q <= ready_count_d;
      build_sel_q   <= build_sel_d;
      rd_idx_q      <= rd_idx_d;
      rd_len_q      <= rd_len_d;
      pv_q          <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_cv_q   <= p_cv_d;
    p_last_q <= p_last_d;
    p_idx_q  <= p_idx_d;
    p_len_q  <= p_len_d;
  end

  cla_ram #(
    .Width(7),
    .Depth(Depth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(cmd_i.ch),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign res_push_o        = pv_q;
  assign res_o.char_out    = p_cv_q ? rdata : 7'd0;
  assign res_o.char_index  = 6'(p_idx_q);
  assign res_o.char_valid  = p_cv_q;
  assign res_o.line_length = 6'(p_len_q);
  assign res_o.last        = p_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> rd_idx_q < rd_len_q)
    else $error("Read-out index ran past the line length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> ready_count_q == '0)
    else $error("A line became pending during read-out.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> int'(res_count_i) < ResDepth)
    else $error("Result pushed into a full result queue.");

endmodule
